### rtl/cns_pkg.sv
package cns_pkg;

    // Fixed field widths of the item and result channels.
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 12;
    localparam int VALUE_W  = 13;
    localparam int WIN_W    = 16;
    localparam int NODE_W   = 10;
    localparam int DEG_W    = 13;
    localparam int IDX_W    = 14;
    localparam int WDEG_W   = 28;
    localparam int LOOP_W   = 16;
    localparam int NCOUNT_W = 11;
    localparam int CFG_IX_W = 1;
    localparam int CFG_D_W  = 11;

    // Default sizes of the stores.
    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic [WDEG_W-1:0] WDEG_MAX = '1;

    // Operation codes carried by an item.
    localparam logic [OP_W-1:0] OP_WR_DEG  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_LINK = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IX_W-1:0] CFG_WEIGHTED   = 1'd1;

    // Step numbers of the microprogram.
    typedef logic [2:0] t_step;
    localparam t_step ST_WAIT   = 3'd0;
    localparam t_step ST_RDPREV = 3'd1;
    localparam t_step ST_RDEND  = 3'd2;
    localparam t_step ST_SETUP  = 3'd3;
    localparam t_step ST_WALK   = 3'd4;
    localparam t_step ST_DRAIN  = 3'd5;
    localparam t_step ST_FINISH = 3'd6;
    localparam t_step ST_ERR    = 3'd7;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_QUERY    = 3'd1,
        C_BAD      = 3'd2,
        C_MORE     = 3'd3,
        C_OUT_FREE = 3'd4
    } t_cond;

    // One control word of the microprogram.
    typedef struct packed {
        logic  accept;   // item port open
        t_cond cond;     // jump condition
        t_step target;   // jump target when the condition holds
        logic  hold;     // stay on this step when the condition fails
        logic  rd_prev;  // read degree entry of the previous node
        logic  rd_end;   // latch range start, read degree entry of the node
        logic  setup;    // latch range end, clear the walk registers
        logic  walk;     // read one link entry per cycle while more remain
        logic  ld_res;   // load the result register with the walk outcome
        logic  ld_err;   // load the result register with an error result
    } t_ctrl;

    // Microprogram held as a read-only table.
    function automatic t_ctrl ucode(input t_step pc);
        t_ctrl cw;
        cw = '{accept: 1'b0, cond: C_NEVER, target: ST_WAIT, hold: 1'b0,
               rd_prev: 1'b0, rd_end: 1'b0, setup: 1'b0, walk: 1'b0,
               ld_res: 1'b0, ld_err: 1'b0};
        unique case (pc)
            ST_WAIT: begin
                cw.accept = 1'b1;
                cw.cond   = C_QUERY;
                cw.target = ST_RDPREV;
                cw.hold   = 1'b1;
            end
            ST_RDPREV: begin
                cw.rd_prev = 1'b1;
                cw.cond    = C_BAD;
                cw.target  = ST_ERR;
            end
            ST_RDEND: begin
                cw.rd_end = 1'b1;
            end
            ST_SETUP: begin
                cw.setup = 1'b1;
            end
            ST_WALK: begin
                cw.walk   = 1'b1;
                cw.cond   = C_MORE;
                cw.target = ST_WALK;
            end
            ST_DRAIN: begin
                cw.cond = C_NEVER;
            end
            ST_FINISH: begin
                cw.ld_res = 1'b1;
                cw.cond   = C_OUT_FREE;
                cw.target = ST_WAIT;
                cw.hold   = 1'b1;
            end
            ST_ERR: begin
                cw.ld_err = 1'b1;
                cw.cond   = C_OUT_FREE;
                cw.target = ST_WAIT;
                cw.hold   = 1'b1;
            end
            default: begin
                cw.cond = C_NEVER;
            end
        endcase
        return cw;
    endfunction

endpackage

### rtl/csr_neighbor_scan.sv
// Degree and self-loop queries on a graph held in compressed sparse row form. Write items
// load the cumulative degree table (operation 0) and the neighbor and weight stores
// (operation 1); these stores are not cleared by reset and must be written before they are
// read. A query item (operation 2) returns one result: the neighbor count, the total edge
// weight (saturating at 2^28-1, or the count when unweighted), the weight of the first
// self-loop and an error flag for a node at or beyond node_count. A query walks the entries
// of the node's range that lie inside the link store through the single read port of the
// link stores, one entry per cycle; an invalid node skips the walk. A finished result waits
// in an output register while the next item is taken; a further query stalls only at its
// last step until that register is free.
module csr_neighbor_scan #(
    parameter int MAX_NODES   = cns_pkg::DEF_MAX_NODES,
    parameter int MAX_ENTRIES = cns_pkg::DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS = cns_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [cns_pkg::CFG_IX_W-1:0]  i_cfg_index,
    input  logic [cns_pkg::CFG_D_W-1:0]   i_cfg_data,
    // item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cns_pkg::OP_W-1:0]      i_operation,
    input  logic [cns_pkg::SLOT_W-1:0]    i_slot,
    input  logic [cns_pkg::VALUE_W-1:0]   i_entry_value,
    input  logic [cns_pkg::WIN_W-1:0]     i_edge_weight_in,
    input  logic [cns_pkg::NODE_W-1:0]    i_query_node,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cns_pkg::DEG_W-1:0]     o_neighbor_count,
    output logic [cns_pkg::WDEG_W-1:0]    o_weight_total,
    output logic [cns_pkg::LOOP_W-1:0]    o_selfloop_weight,
    output logic                          o_node_error
);
    import cns_pkg::*;

    localparam int ND_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EN_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Configuration registers.
    logic [NCOUNT_W-1:0] r_node_count;
    logic                r_weighted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_weighted   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data[NCOUNT_W-1:0];
                CFG_WEIGHTED:   r_weighted   <= i_cfg_data[0];
                default:        r_node_count <= r_node_count;
            endcase
        end
    end

    // Sequencer: step counter and the control word it selects.
    t_step r_pc, n_pc;
    t_ctrl cw;
    logic  in_fire, out_free, bad, more, cond_ok;

    // Datapath registers.
    logic [NODE_W-1:0]      r_node;
    logic [DEG_W-1:0]       r_start, r_count, r_left;
    logic [IDX_W-1:0]       r_idx;
    logic [DEG_W-1:0]       r_deg_q;
    logic [NODE_W-1:0]      r_nid_q;
    logic [WEIGHT_BITS-1:0] r_wt_q;
    logic                   r_lvld;
    logic [WDEG_W-1:0]      r_sum;
    logic [LOOP_W-1:0]      r_loop;
    logic                   r_found;
    logic                   issue;

    assign cw         = ucode(r_pc);
    assign o_in_ready = cw.accept;
    assign in_fire    = i_in_valid & cw.accept;
    assign out_free   = !o_out_valid || i_out_ready;
    assign bad        = (32'(r_node) >= 32'(r_node_count)) || (32'(r_node) >= 32'(MAX_NODES));
    assign more       = (r_left != '0) && (32'(r_idx) < 32'(MAX_ENTRIES));
    assign issue      = cw.walk && more;

    // Jump condition of the current step.
    always_comb begin
        case (cw.cond)
            C_QUERY:    cond_ok = in_fire && (i_operation == OP_QUERY);
            C_BAD:      cond_ok = bad;
            C_MORE:     cond_ok = more;
            C_OUT_FREE: cond_ok = out_free;
            default:    cond_ok = 1'b0;
        endcase
    end

    // Next step: jump, stay or fall through.
    always_comb begin
        if (cond_ok) begin
            n_pc = cw.target;
        end else if (cw.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Cumulative degree store with one registered read port.
    logic [DEG_W-1:0] mem_deg [MAX_NODES];
    logic [ND_AW-1:0] deg_raddr;

    always_comb begin
        if (cw.rd_prev) begin
            deg_raddr = ND_AW'(32'(r_node) - 32'd1);
        end else begin
            deg_raddr = ND_AW'(32'(r_node));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_operation == OP_WR_DEG) && (32'(i_slot) < 32'(MAX_NODES))) begin
            mem_deg[ND_AW'(32'(i_slot))] <= i_entry_value;
        end
        r_deg_q <= mem_deg[deg_raddr];
    end

    // Neighbor id and weight stores, read one entry a cycle during the walk.
    logic [NODE_W-1:0]      mem_nid [MAX_ENTRIES];
    logic [WEIGHT_BITS-1:0] mem_wt  [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_operation == OP_WR_LINK) && (32'(i_slot) < 32'(MAX_ENTRIES))) begin
            mem_nid[EN_AW'(32'(i_slot))] <= i_entry_value[NODE_W-1:0];
            mem_wt[EN_AW'(32'(i_slot))]  <= WEIGHT_BITS'(32'(i_edge_weight_in));
        end
        if (issue) begin
            r_nid_q <= mem_nid[EN_AW'(32'(r_idx))];
            r_wt_q  <= mem_wt[EN_AW'(32'(r_idx))];
        end
    end

    // Range bounds and walk counters.
    logic [DEG_W-1:0] range_len;
    assign range_len = (r_deg_q >= r_start) ? (r_deg_q - r_start) : '0;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_node <= i_query_node;
        end
        if (cw.rd_end) begin
            r_start <= (r_node == '0) ? '0 : r_deg_q;
        end
        if (cw.setup) begin
            r_count <= range_len;
            r_left  <= range_len;
            r_idx   <= IDX_W'(r_start);
        end else if (issue) begin
            r_left <= r_left - DEG_W'(1);
            r_idx  <= r_idx + IDX_W'(1);
        end
    end

    // Accumulation of weights and search for the first self-loop.
    logic [32:0] sum_ext;
    assign sum_ext = 33'(r_sum) + 33'(r_wt_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= 1'b0;
        end else begin
            r_lvld <= issue;
        end
        if (cw.setup) begin
            r_sum   <= '0;
            r_loop  <= '0;
            r_found <= 1'b0;
        end else if (r_lvld) begin
            r_sum <= (sum_ext > 33'(WDEG_MAX)) ? WDEG_MAX : sum_ext[WDEG_W-1:0];
            if (!r_found && (r_nid_q == r_node)) begin
                r_found <= 1'b1;
                r_loop  <= LOOP_W'(32'(r_wt_q));
            end
        end
    end

    // Result register: holds a finished result until it is taken.
    logic ld;
    assign ld = (cw.ld_res || cw.ld_err) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (ld) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (ld) begin
            if (cw.ld_err) begin
                o_neighbor_count  <= '0;
                o_weight_total    <= '0;
                o_selfloop_weight <= '0;
                o_node_error      <= 1'b1;
            end else begin
                o_neighbor_count  <= r_count;
                o_weight_total    <= r_weighted ? r_sum : WDEG_W'(r_count);
                o_selfloop_weight <= !r_found ? '0 : (r_weighted ? r_loop : LOOP_W'(1));
                o_node_error      <= 1'b0;
            end
        end
    end

    // A link read is only in flight during the walk or the step after it.
    a_lvld_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvld |-> (r_pc == ST_WALK || r_pc == ST_DRAIN))
        else $error("link read data outside the walk");

    // An error result carries no counts.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_node_error) |->
            (o_neighbor_count == '0 && o_weight_total == '0 && o_selfloop_weight == '0))
        else $error("error result with non-zero fields");

    // Unweighted graphs report the count as the weight total.
    a_unweighted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_node_error && !r_weighted) |->
            (o_weight_total == WDEG_W'(o_neighbor_count)))
        else $error("unweighted total differs from count");

endmodule
